// ----- hw/rtl/u8v_pkg.sv -----
// Package with the shared types, constants and helper functions of the UTF-8 name validator.
`timescale 1ns / 1ps

package u8v_pkg;

    localparam int MAX_INPUT_BYTES_DEF = 65536;
    localparam int OUT_POS_W           = 17;
    localparam int LIMIT_W             = 6;
    // Counts saturate at the limit plus one, so they can reach 64.
    localparam int CNT_W               = LIMIT_W + 1;
    localparam int CP_W                = 21;

    localparam logic [LIMIT_W-1:0] MAX_POINTS_RESET = 6'd32;

    // Number of continuation bytes that follow a lead byte.
    localparam logic [1:0] LEAD_ONE   = 2'd0;
    localparam logic [1:0] LEAD_TWO   = 2'd1;
    localparam logic [1:0] LEAD_THREE = 2'd2;
    localparam logic [1:0] LEAD_FOUR  = 2'd3;

    typedef struct packed {
        logic [1:0]      cont_left;
        logic [1:0]      lead_len;
        logic [CP_W-1:0] code_accum;
        logic            bad_seen;
        logic            content_seen;
        logic [CNT_W-1:0] span_points;
        logic [CNT_W-1:0] pending_space;
    } dec_state_t;

    function automatic logic is_space(input logic [CP_W-1:0] cp);
        return cp inside {21'h20, 21'ha0, 21'h1680, [21'h2000:21'h200a], 21'h2028,
                          21'h2029, 21'h202f, 21'h205f, 21'h3000, 21'hfeff};
    endfunction

    function automatic logic is_bad_point(input logic [CP_W-1:0] cp, input logic [1:0] len);
        logic overlong;
        overlong = (len == LEAD_TWO   && cp < 21'h80)  ||
                   (len == LEAD_THREE && cp < 21'h800) ||
                   (len == LEAD_FOUR  && cp < 21'h10000);
        return overlong || cp > 21'h10ffff || (cp inside {[21'hd800:21'hdfff]}) ||
               cp < 21'h20 || (cp inside {[21'h7f:21'h9f]});
    endfunction

endpackage

// ----- hw/rtl/u8v_in_if.sv -----
// Stream interface that carries one string byte a word.
`timescale 1ns / 1ps

interface u8v_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;

    modport source (output valid, data_byte, has_byte, is_last, input ready);
    modport sink   (input valid, data_byte, has_byte, is_last, output ready);
endinterface

// ----- hw/rtl/u8v_res_if.sv -----
// Stream interface that carries one validation result a word.
`timescale 1ns / 1ps

interface u8v_res_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 valid_res;
    logic [u8v_pkg::OUT_POS_W-1:0]        name_start;
    logic [u8v_pkg::OUT_POS_W-1:0]        name_bytes;
    logic [u8v_pkg::LIMIT_W-1:0]          name_points;

    modport source (output valid, valid_res, name_start, name_bytes, name_points, input ready);
    modport sink   (input valid, valid_res, name_start, name_bytes, name_points, output ready);
endinterface

// ----- hw/rtl/u8v_step.sv -----
// Next-state logic of the decoder and trimmer for one byte.
`timescale 1ns / 1ps

module u8v_step #(
    parameter int MAX_INPUT_BYTES = u8v_pkg::MAX_INPUT_BYTES_DEF,
    parameter int POS_W           = $clog2(MAX_INPUT_BYTES + 1)
) (
    input  u8v_pkg::dec_state_t             cur,
    input  logic [POS_W-1:0]                byte_pos,
    input  logic [POS_W-1:0]                point_start,
    input  logic [POS_W-1:0]                span_start,
    input  logic [POS_W-1:0]                span_end,
    input  logic [7:0]                      data_byte,
    input  logic                            has_byte,
    input  logic [u8v_pkg::LIMIT_W-1:0]     max_points,
    output u8v_pkg::dec_state_t             nxt,
    output logic [POS_W-1:0]                byte_pos_next,
    output logic [POS_W-1:0]                point_start_next,
    output logic [POS_W-1:0]                span_start_next,
    output logic [POS_W-1:0]                span_end_next
);

    logic [u8v_pkg::CNT_W-1:0] cap;
    logic [u8v_pkg::CNT_W:0]   pend_sum;
    logic [u8v_pkg::CNT_W:0]   span_sum;
    logic                      finish;

    assign cap      = {1'b0, max_points} + u8v_pkg::CNT_W'(1);
    assign pend_sum = {1'b0, cur.pending_space} + (u8v_pkg::CNT_W + 1)'(1);
    assign span_sum = {1'b0, cur.span_points} + {1'b0, cur.pending_space}
                      + (u8v_pkg::CNT_W + 1)'(1);

    always_comb
    begin
        nxt              = cur;
        byte_pos_next    = byte_pos;
        point_start_next = point_start;
        span_start_next  = span_start;
        span_end_next    = span_end;
        finish           = 1'b0;

        if (has_byte && !cur.bad_seen)
        begin
            if (byte_pos >= POS_W'(MAX_INPUT_BYTES))
            begin
                nxt.bad_seen = 1'b1;
            end
            else if (cur.cont_left == 2'd0)
            begin
                point_start_next = byte_pos;
                if (data_byte < 8'h80)
                begin
                    nxt.lead_len   = u8v_pkg::LEAD_ONE;
                    nxt.code_accum = {13'd0, data_byte};
                end
                else if (data_byte inside {[8'hc2:8'hdf]})
                begin
                    nxt.lead_len   = u8v_pkg::LEAD_TWO;
                    nxt.code_accum = {16'd0, data_byte[4:0]};
                end
                else if (data_byte inside {[8'he0:8'hef]})
                begin
                    nxt.lead_len   = u8v_pkg::LEAD_THREE;
                    nxt.code_accum = {17'd0, data_byte[3:0]};
                end
                else if (data_byte inside {[8'hf0:8'hf4]})
                begin
                    nxt.lead_len   = u8v_pkg::LEAD_FOUR;
                    nxt.code_accum = {18'd0, data_byte[2:0]};
                end
                else
                begin
                    nxt.bad_seen = 1'b1;
                end
                nxt.cont_left = nxt.lead_len;
            end
            else if (data_byte[7:6] != 2'b10)
            begin
                nxt.bad_seen = 1'b1;
            end
            else
            begin
                nxt.code_accum = {cur.code_accum[14:0], data_byte[5:0]};
                nxt.cont_left  = cur.cont_left - 2'd1;
            end

            if (!nxt.bad_seen)
            begin
                byte_pos_next = byte_pos + POS_W'(1);
                finish        = (nxt.cont_left == 2'd0);
            end
        end

        if (finish)
        begin
            if (u8v_pkg::is_bad_point(nxt.code_accum, nxt.lead_len))
            begin
                nxt.bad_seen = 1'b1;
            end
            else if (u8v_pkg::is_space(nxt.code_accum))
            begin
                // Leading whitespace is dropped; inner whitespace is held until content follows.
                if (cur.content_seen)
                begin
                    nxt.pending_space = (pend_sum > {1'b0, cap}) ? cap
                                        : pend_sum[u8v_pkg::CNT_W-1:0];
                end
            end
            else
            begin
                if (!cur.content_seen)
                begin
                    nxt.content_seen = 1'b1;
                    span_start_next  = point_start_next;
                    nxt.span_points  = u8v_pkg::CNT_W'(1);
                end
                else
                begin
                    nxt.span_points = (span_sum > {1'b0, cap}) ? cap
                                      : span_sum[u8v_pkg::CNT_W-1:0];
                end
                nxt.pending_space = '0;
                span_end_next     = byte_pos_next;
            end
        end
    end

endmodule

// ----- hw/rtl/utf8_name_validate_trim.sv -----
// Top level of the streaming UTF-8 name validator and whitespace trimmer.
//
// The string arrives on str, one byte a word; has_byte low marks a word without a
// byte and is_last marks the final word of the string. For the final word one result
// word leaves on res: validity, the byte offset and byte length of the span without
// leading and trailing Unicode whitespace, and its code point count (all zero when the
// string is invalid or the span is empty). Other words give no result.
// cfg_we writes cfg_wdata as the greatest number of code points allowed in the span;
// the user must write it only while the block is idle; the block does not enforce this.
// A word passes an input register and then the decode logic into the result
// register. One word is taken every cycle unless a final word waits on a full
// result register that the receiver has not freed; the decoder state is updated
// once per word. A stalled receiver holds the result register, and the block keeps taking
// words that give no result until a second result is ready to be written.
// Reset clears the string state, empties both registers and sets the limit to 32.
`timescale 1ns / 1ps

module utf8_name_validate_trim #(
    parameter int MAX_INPUT_BYTES = u8v_pkg::MAX_INPUT_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [u8v_pkg::LIMIT_W-1:0]     cfg_wdata,
    u8v_in_if.sink                          str,
    u8v_res_if.source                       res
);

    localparam int POS_W = $clog2(MAX_INPUT_BYTES + 1);

    logic [u8v_pkg::LIMIT_W-1:0] max_points_reg;

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_has_reg;
    logic       s1_last_reg;
    logic       s1_fire;

    u8v_pkg::dec_state_t dec_reg;
    u8v_pkg::dec_state_t dec_next;
    u8v_pkg::dec_state_t step_state;
    logic [POS_W-1:0] byte_pos_reg,    byte_pos_next,    step_pos;
    logic [POS_W-1:0] point_start_reg, point_start_next, step_point;
    logic [POS_W-1:0] span_start_reg,  span_start_next,  step_start;
    logic [POS_W-1:0] span_end_reg,    span_end_next,    step_end;

    logic                          out_valid_reg;
    logic                          out_ok_reg;
    logic [u8v_pkg::OUT_POS_W-1:0] out_start_reg;
    logic [u8v_pkg::OUT_POS_W-1:0] out_bytes_reg;
    logic [u8v_pkg::LIMIT_W-1:0]   out_points_reg;

    logic                          ok;
    logic                          show;
    logic [POS_W-1:0]              span_len;

    // A word without a result always moves on; a final word needs the result register.
    assign s1_fire   = s1_valid_reg && (!s1_last_reg || !out_valid_reg || res.ready);
    assign str.ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_points_reg <= u8v_pkg::MAX_POINTS_RESET;
        end
        else if (cfg_we)
        begin
            max_points_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (str.ready)
        begin
            s1_valid_reg <= str.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (str.ready && str.valid)
        begin
            s1_byte_reg <= str.data_byte;
            s1_has_reg  <= str.has_byte;
            s1_last_reg <= str.is_last;
        end
    end

    u8v_step #(
        .MAX_INPUT_BYTES (MAX_INPUT_BYTES),
        .POS_W           (POS_W)
    ) u_step (
        .cur              (dec_reg),
        .byte_pos         (byte_pos_reg),
        .point_start      (point_start_reg),
        .span_start       (span_start_reg),
        .span_end         (span_end_reg),
        .data_byte        (s1_byte_reg),
        .has_byte         (s1_has_reg),
        .max_points       (max_points_reg),
        .nxt              (step_state),
        .byte_pos_next    (step_pos),
        .point_start_next (step_point),
        .span_start_next  (step_start),
        .span_end_next    (step_end)
    );

    // The final word of a string returns all string state to its cleared value.
    always_comb
    begin
        dec_next         = dec_reg;
        byte_pos_next    = byte_pos_reg;
        point_start_next = point_start_reg;
        span_start_next  = span_start_reg;
        span_end_next    = span_end_reg;
        if (s1_fire)
        begin
            if (s1_last_reg)
            begin
                dec_next         = '0;
                byte_pos_next    = '0;
                point_start_next = '0;
                span_start_next  = '0;
                span_end_next    = '0;
            end
            else
            begin
                dec_next         = step_state;
                byte_pos_next    = step_pos;
                point_start_next = step_point;
                span_start_next  = step_start;
                span_end_next    = step_end;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_reg         <= '0;
            byte_pos_reg    <= '0;
            point_start_reg <= '0;
            span_start_reg  <= '0;
            span_end_reg    <= '0;
        end
        else
        begin
            dec_reg         <= dec_next;
            byte_pos_reg    <= byte_pos_next;
            point_start_reg <= point_start_next;
            span_start_reg  <= span_start_next;
            span_end_reg    <= span_end_next;
        end
    end

    assign ok = !step_state.bad_seen && step_state.cont_left == 2'd0 &&
                step_state.span_points <= {1'b0, max_points_reg};
    assign show     = ok && step_state.content_seen;
    assign span_len = step_end - step_start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last_reg)
        begin
            out_ok_reg     <= ok;
            out_start_reg  <= show ? u8v_pkg::OUT_POS_W'(step_start) : '0;
            out_bytes_reg  <= show ? u8v_pkg::OUT_POS_W'(span_len) : '0;
            out_points_reg <= show ? step_state.span_points[u8v_pkg::LIMIT_W-1:0] : '0;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.valid_res   = out_ok_reg;
    assign res.name_start  = out_start_reg;
    assign res.name_bytes  = out_bytes_reg;
    assign res.name_points = out_points_reg;

    // A valid result never reports more code points than the limit allows.
    a_points_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.valid_res |-> res.name_points <= max_points_reg)
        else $error("valid result exceeds the code point limit");

    // An invalid result carries an empty span.
    a_invalid_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.valid_res |->
            res.name_start == '0 && res.name_bytes == '0 && res.name_points == '0)
        else $error("invalid result carries a non-empty span");

    // A final word waiting behind a stalled result must not be lost.
    a_last_word_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_last_reg && out_valid_reg && !res.ready |=>
            s1_valid_reg && s1_last_reg && out_valid_reg)
        else $error("final word dropped while the result register was full");

    // After the final word is taken the string state is cleared.
    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_last_reg |=> byte_pos_reg == '0 && dec_reg == '0)
        else $error("string state not cleared after the final word");

endmodule

// ----- verif/utf8_name_validate_trim_tb.sv -----
// Self-checking testbench for the streaming UTF-8 name validator and whitespace trimmer.
`timescale 1ns / 1ps

module utf8_name_validate_trim_tb;

    localparam int WATCHDOG_CYCLES = 1000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int HOLD_CYCLES     = 150;

    typedef logic [7:0] byte_q_t[$];

    typedef struct packed {
        logic                          ok;
        logic [u8v_pkg::OUT_POS_W-1:0] start;
        logic [u8v_pkg::OUT_POS_W-1:0] len;
        logic [u8v_pkg::LIMIT_W-1:0]   npts;
    } name_result_t;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [u8v_pkg::LIMIT_W-1:0] cfg_wdata;

    u8v_in_if  str_if ();
    u8v_res_if res_if ();

    utf8_name_validate_trim u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .str       (str_if),
        .res       (res_if)
    );

    // Shadow copy of the decoder and trimmer state.
    logic [u8v_pkg::LIMIT_W-1:0]   limit_pts;
    logic [u8v_pkg::OUT_POS_W-1:0] rx_pos;
    logic [1:0]                    cont_due;
    logic [1:0]                    seq_len;
    logic [u8v_pkg::CP_W-1:0]      cp_acc;
    logic [u8v_pkg::OUT_POS_W-1:0] cp_start;
    logic                          err_seen;
    logic                          text_seen;
    logic [u8v_pkg::OUT_POS_W-1:0] span_first;
    logic [u8v_pkg::OUT_POS_W-1:0] span_past;
    logic [u8v_pkg::CNT_W-1:0]     span_cnt;
    logic [u8v_pkg::CNT_W-1:0]     space_cnt;

    name_result_t expected_names[$];
    int           errors;
    int unsigned  bytes_sent;
    int           quiet_cycles;
    bit           gaps_on;
    bit           hold_req;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic void clear_name();
        rx_pos     = '0;
        cont_due   = '0;
        seq_len    = u8v_pkg::LEAD_ONE;
        cp_acc     = '0;
        cp_start   = '0;
        err_seen   = 1'b0;
        text_seen  = 1'b0;
        span_first = '0;
        span_past  = '0;
        span_cnt   = '0;
        space_cnt  = '0;
    endfunction

    // Counts stop at one above the limit, which is enough to tell that it was exceeded.
    function automatic logic [u8v_pkg::CNT_W-1:0] cap_count(input int v);
        int cap;
        cap = int'(limit_pts) + 1;
        return (v > cap) ? u8v_pkg::CNT_W'(cap) : u8v_pkg::CNT_W'(v);
    endfunction

    function automatic logic is_trim_space(input logic [u8v_pkg::CP_W-1:0] cp);
        return cp == 21'h20 || cp == 21'ha0 || cp == 21'h1680 ||
               (cp >= 21'h2000 && cp <= 21'h200a) || cp == 21'h2028 || cp == 21'h2029 ||
               cp == 21'h202f || cp == 21'h205f || cp == 21'h3000 || cp == 21'hfeff;
    endfunction

    function automatic void close_point(input logic [u8v_pkg::CP_W-1:0] cp);
        logic rejected;
        rejected = (seq_len == u8v_pkg::LEAD_TWO && cp < 21'h80) ||
                   (seq_len == u8v_pkg::LEAD_THREE && cp < 21'h800) ||
                   (seq_len == u8v_pkg::LEAD_FOUR && cp < 21'h10000) ||
                   cp > 21'h10ffff || (cp >= 21'hd800 && cp <= 21'hdfff) ||
                   cp < 21'h20 || (cp >= 21'h7f && cp <= 21'h9f);
        if (rejected)
        begin
            err_seen = 1'b1;
        end
        else if (is_trim_space(cp))
        begin
            if (text_seen)
                space_cnt = cap_count(int'(space_cnt) + 1);
        end
        else
        begin
            if (!text_seen)
            begin
                text_seen  = 1'b1;
                span_first = cp_start;
                span_cnt   = cap_count(1);
            end
            else
            begin
                span_cnt = cap_count(int'(span_cnt) + int'(space_cnt) + 1);
            end
            space_cnt = '0;
            span_past = rx_pos;
        end
    endfunction

    function automatic void consume_byte(input logic [7:0] b);
        if (err_seen)
            return;
        if (int'(rx_pos) >= u8v_pkg::MAX_INPUT_BYTES_DEF)
        begin
            err_seen = 1'b1;
            return;
        end
        if (cont_due == 2'd0)
        begin
            cp_start = rx_pos;
            if (b < 8'h80)
            begin
                seq_len = u8v_pkg::LEAD_ONE;
                cp_acc  = u8v_pkg::CP_W'(b);
            end
            else if (b >= 8'hc2 && b <= 8'hdf)
            begin
                seq_len = u8v_pkg::LEAD_TWO;
                cp_acc  = u8v_pkg::CP_W'(b[4:0]);
            end
            else if (b >= 8'he0 && b <= 8'hef)
            begin
                seq_len = u8v_pkg::LEAD_THREE;
                cp_acc  = u8v_pkg::CP_W'(b[3:0]);
            end
            else if (b >= 8'hf0 && b <= 8'hf4)
            begin
                seq_len = u8v_pkg::LEAD_FOUR;
                cp_acc  = u8v_pkg::CP_W'(b[2:0]);
            end
            else
            begin
                err_seen = 1'b1;
                return;
            end
            cont_due = seq_len;
        end
        else
        begin
            if (b[7:6] != 2'b10)
            begin
                err_seen = 1'b1;
                return;
            end
            cp_acc   = {cp_acc[u8v_pkg::CP_W-7:0], b[5:0]};
            cont_due = cont_due - 2'd1;
        end
        rx_pos = rx_pos + 1'b1;
        if (cont_due == 2'd0)
            close_point(cp_acc);
    endfunction

    function automatic void predict_name_word(input logic [7:0] b, input bit has, input bit last);
        name_result_t r;
        if (has)
            consume_byte(b);
        if (!last)
            return;
        r    = '0;
        r.ok = !err_seen && cont_due == 2'd0 && span_cnt <= u8v_pkg::CNT_W'(limit_pts);
        if (r.ok && text_seen)
        begin
            r.start = span_first;
            r.len   = span_past - span_first;
            r.npts  = (span_cnt > u8v_pkg::CNT_W'(63)) ? u8v_pkg::LIMIT_W'(63)
                                                       : span_cnt[u8v_pkg::LIMIT_W-1:0];
        end
        expected_names.push_back(r);
        clear_name();
    endfunction

    task automatic send_word(input logic [7:0] b, input bit has, input bit last);
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            str_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        str_if.valid     <= 1'b1;
        str_if.data_byte <= b;
        str_if.has_byte  <= has;
        str_if.is_last   <= last;
        @(posedge clk);
        while (!str_if.ready)
            @(posedge clk);
        predict_name_word(b, has, last);
        if (has)
            bytes_sent++;
    endtask

    // With end_word set, the string is closed by a separate word that carries no byte.
    task automatic send_name(input byte_q_t q, input bit end_word);
        for (int i = 0; i < q.size(); i++)
        begin
            if (gaps_on && $urandom_range(0, 15) == 0)
                send_word(8'($urandom), 1'b0, 1'b0);
            send_word(q[i], 1'b1, (i == q.size() - 1) && !end_word);
        end
        if (end_word || q.size() == 0)
            send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic wait_idle();
        str_if.valid <= 1'b0;
        while (expected_names.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_limit(input logic [u8v_pkg::LIMIT_W-1:0] v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        limit_pts = v;
    endtask

    function automatic void put_point(ref byte_q_t q, input int unsigned cp);
        if (cp < 32'h80)
        begin
            q.push_back(8'(cp));
        end
        else if (cp < 32'h800)
        begin
            q.push_back(8'hc0 | 8'(cp >> 6));
            q.push_back(8'h80 | 8'(cp & 32'h3f));
        end
        else if (cp < 32'h10000)
        begin
            q.push_back(8'he0 | 8'(cp >> 12));
            q.push_back(8'h80 | 8'((cp >> 6) & 32'h3f));
            q.push_back(8'h80 | 8'(cp & 32'h3f));
        end
        else
        begin
            q.push_back(8'hf0 | 8'(cp >> 18));
            q.push_back(8'h80 | 8'((cp >> 12) & 32'h3f));
            q.push_back(8'h80 | 8'((cp >> 6) & 32'h3f));
            q.push_back(8'h80 | 8'(cp & 32'h3f));
        end
    endfunction

    function automatic int unsigned random_point();
        int unsigned blanks[10];
        blanks = '{32'h20, 32'ha0, 32'h1680, 32'h2000, 32'h2028, 32'h2029, 32'h202f,
                   32'h205f, 32'h3000, 32'hfeff};
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7: return $urandom_range(32'h21, 32'h7e);
            8, 9:                   return 32'h20;
            10:                     return blanks[$urandom_range(0, 9)];
            11:                     return 32'h2000 + $urandom_range(0, 10);
            12, 13:                 return $urandom_range(32'h80, 32'h7ff);
            14, 15:                 return $urandom_range(32'h800, 32'hffff);
            16, 17:                 return $urandom_range(32'h10000, 32'h10ffff);
            18:                     return $urandom_range(0, 32'h1f);
            default:                return $urandom_range(32'h61, 32'h7a);
        endcase
    endfunction

    // Mostly well-formed names with random content; the rest is damaged or plain noise.
    function automatic void build_random_name(ref byte_q_t q);
        int n;
        int idx;
        q.delete();
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 12);
        repeat (n) put_point(q, random_point());
        idx = (q.size() > 0) ? $urandom_range(0, q.size() - 1) : 0;
        case ($urandom_range(0, 9))
            0:
            begin
                if (q.size() > 0)
                    q[idx] = 8'($urandom);
            end
            1:
            begin
                if (q.size() > 0)
                    void'(q.pop_back());
            end
            2: q.insert(idx, 8'($urandom));
            3:
            begin
                q.delete();
                repeat ($urandom_range(1, 12)) q.push_back(8'($urandom));
            end
            default: ;
        endcase
    endfunction

    task automatic test_basic_names();
        byte_q_t s;
        s = '{8'h61};
        send_name(s, 1'b0);
        s = '{8'h20, 8'h20, 8'h61, 8'h62, 8'h20, 8'h20};
        send_name(s, 1'b1);
        s.delete();
        send_name(s, 1'b0);
        // Whitespace code points only, each kind once and both ends of the U+2000 range: the span stays empty.
        s = '{8'h20, 8'hc2, 8'ha0, 8'he1, 8'h9a, 8'h80, 8'he2, 8'h80, 8'h80, 8'he2, 8'h80,
              8'h8a, 8'he2, 8'h80, 8'ha8, 8'he2, 8'h80, 8'ha9, 8'he2, 8'h80, 8'haf, 8'he2,
              8'h81, 8'h9f, 8'he3, 8'h80, 8'h80, 8'hef, 8'hbb, 8'hbf};
        send_name(s, 1'b0);
        // Inner whitespace counts towards the span, with words carrying no byte in between.
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'hff, 1'b0, 1'b0);
        send_word(8'he2, 1'b1, 1'b0);
        send_word(8'h80, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'h85, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h20, 1'b1, 1'b1);
        s = '{8'hf0, 8'h9f, 8'h98, 8'h80, 8'hf4, 8'h8f, 8'hbf, 8'hbf, 8'h7e, 8'hc2, 8'ha1};
        send_name(s, 1'b0);
    endtask

    task automatic test_malformed();
        byte_q_t s;
        s = '{8'h80};                           send_name(s, 1'b0);
        s = '{8'hc0, 8'haf};                    send_name(s, 1'b0);
        s = '{8'hc1, 8'hbf};                    send_name(s, 1'b1);
        s = '{8'hf5, 8'h80, 8'h80, 8'h80};      send_name(s, 1'b0);
        s = '{8'hff};                           send_name(s, 1'b0);
        s = '{8'hc3, 8'h41};                    send_name(s, 1'b0);
        s = '{8'h61, 8'he2, 8'h82};             send_name(s, 1'b0);
        s = '{8'he2, 8'h82};                    send_name(s, 1'b1);
        s = '{8'he0, 8'h80, 8'h80};             send_name(s, 1'b0);
        s = '{8'hf0, 8'h80, 8'h80, 8'h80};      send_name(s, 1'b0);
        s = '{8'hed, 8'ha0, 8'h80};             send_name(s, 1'b0);
        s = '{8'hed, 8'hbf, 8'hbf};             send_name(s, 1'b0);
        s = '{8'hf4, 8'h90, 8'h80, 8'h80};      send_name(s, 1'b0);
        s = '{8'hc3, 8'ha9, 8'h80};             send_name(s, 1'b0);
        // Bytes after the first error must not revive the string.
        s = '{8'hfe, 8'h61, 8'h62};             send_name(s, 1'b0);
    endtask

    task automatic test_controls();
        byte_q_t s;
        s = '{8'h00};                           send_name(s, 1'b0);
        s = '{8'h1f};                           send_name(s, 1'b0);
        s = '{8'h61, 8'h09, 8'h62};             send_name(s, 1'b0);
        s = '{8'h7f};                           send_name(s, 1'b0);
        s = '{8'hc2, 8'h80};                    send_name(s, 1'b0);
        s = '{8'hc2, 8'h9f};                    send_name(s, 1'b1);
    endtask

    task automatic test_limits();
        byte_q_t s;
        set_limit(6'd1);
        s = '{8'h61};                           send_name(s, 1'b0);
        s = '{8'h61, 8'h62};                    send_name(s, 1'b0);
        s = '{8'h20, 8'h61, 8'h20};             send_name(s, 1'b0);
        s = '{8'h61, 8'h20, 8'h62};             send_name(s, 1'b0);
        set_limit(6'd0);
        s = '{8'h61};                           send_name(s, 1'b0);
        s = '{8'h20, 8'h20, 8'h20};             send_name(s, 1'b0);
        s.delete();                             send_name(s, 1'b0);
        set_limit(6'd63);
        s = '{8'h20};
        repeat (63) s.push_back(8'h61);
        send_name(s, 1'b0);
        s.push_back(8'h62);
        send_name(s, 1'b0);
        repeat (6) s.push_back(8'h63);
        send_name(s, 1'b1);
        s.delete();
        repeat (63) put_point(s, 32'h1f600);
        send_name(s, 1'b0);
        s = '{8'h61};
        repeat (70) s.push_back(8'h20);
        s.push_back(8'h62);
        send_name(s, 1'b0);
        set_limit(u8v_pkg::MAX_POINTS_RESET);
        s.delete();
        repeat (32) s.push_back(8'h78);
        send_name(s, 1'b0);
        s.push_back(8'h79);
        send_name(s, 1'b0);
    endtask

    // The receiver holds off while short names keep coming, so the block must stall its input.
    task automatic test_backpressure();
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++)
            send_word(8'h41 + 8'(i), 1'b1, 1'b1);
        wait_idle();
        gaps_on = 1'b1;
    endtask

    task automatic test_random();
        byte_q_t     s;
        int unsigned stop_at;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       set_limit(u8v_pkg::LIMIT_W'($urandom_range(1, 63)));
                1:       set_limit(6'd63);
                2:       set_limit(u8v_pkg::LIMIT_W'($urandom_range(1, 8)));
                default: set_limit(u8v_pkg::MAX_POINTS_RESET);
            endcase
            gaps_on = (ph != 3);
            stop_at = bytes_sent + 60;
            while (bytes_sent < stop_at)
            begin
                build_random_name(s);
                send_name(s, $urandom_range(0, 3) == 0);
            end
        end
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        str_if.valid     <= 1'b0;
        str_if.data_byte <= '0;
        str_if.has_byte  <= 1'b0;
        str_if.is_last   <= 1'b0;
        errors     = 0;
        bytes_sent = 0;
        gaps_on    = 1'b1;
        hold_req   = 1'b0;
        limit_pts  = u8v_pkg::MAX_POINTS_RESET;
        clear_name();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_basic_names();
        test_malformed();
        test_controls();
        test_limits();
        test_backpressure();
        test_random();
        wait_idle();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("PASS utf8_name_validate_trim");
        else
            $display("FAIL utf8_name_validate_trim");
        $finish;
    end

    initial
    begin
        res_if.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                res_if.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        name_result_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (expected_names.size() == 0)
            begin
                $error("result word arrived with no name outstanding");
                errors++;
            end
            else
            begin
                want = expected_names.pop_front();
                if (res_if.valid_res !== want.ok)
                begin
                    $error("valid_res: expected %0d, actual %0d", want.ok, res_if.valid_res);
                    errors++;
                end
                if (res_if.name_start !== want.start)
                begin
                    $error("name_start: expected %0d, actual %0d", want.start,
                           res_if.name_start);
                    errors++;
                end
                if (res_if.name_bytes !== want.len)
                begin
                    $error("name_bytes: expected %0d, actual %0d", want.len,
                           res_if.name_bytes);
                    errors++;
                end
                if (res_if.name_points !== want.npts)
                begin
                    $error("name_points: expected %0d, actual %0d", want.npts,
                           res_if.name_points);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((str_if.valid && str_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("FAIL utf8_name_validate_trim");
            $finish;
        end
    end

    initial quiet_cycles = 0;

endmodule

// ----- utf8_name_validate_trim.f -----
hw/rtl/u8v_pkg.sv
hw/rtl/u8v_in_if.sv
hw/rtl/u8v_res_if.sv
hw/rtl/u8v_step.sv
hw/rtl/utf8_name_validate_trim.sv
verif/utf8_name_validate_trim_tb.sv
